FILE: rtl/core/pcfs_pkg.sv
// Shared types, codes and channel-step function for the palette fade sequencer.
// No dependencies.
`default_nettype none

package pcfs_pkg;

    localparam int unsigned TDATA_W    = 32;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // request opcodes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_COLOR_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINISH_MODE = 2'd2;

    // finish modes; code 3 behaves as stop
    localparam logic [1:0] MODE_STOP     = 2'd0;
    localparam logic [1:0] MODE_WRAP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic reversing;
        logic halted;
    } t_seq_flags;

    // One channel step toward the target; snaps on overshoot or range exit.
    function automatic logic [7:0] move_channel(input logic [7:0] cur,
                                                input logic [7:0] tgt,
                                                input logic [7:0] w);
        logic [8:0] up;
        logic [8:0] dn;
        logic [7:0] res;
        up  = {1'b0, cur} + {1'b0, w};
        dn  = {1'b0, cur} - {1'b0, w};
        res = cur;
        if (tgt > cur) begin
            if (up[8] || (up[7:0] > tgt)) res = tgt;
            else                          res = up[7:0];
        end else if (tgt < cur) begin
            if (dn[8] || (dn[7:0] < tgt)) res = tgt;
            else                          res = dn[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/palette_color_fade_sequencer.sv
// Results are registered in the output stage, or in the skid stage while output is held.
// Throughput: one request per cycle while skid is empty; RAM read feeds next tick by bypass.
// Reset: synchronous, active low; clears color, target, index, flags, config and handshake.
// Palette RAM contents are not cleared; an entry is undefined until written.
// Depends on pcfs_pkg, pcfs_ram and pcfs_step.
`default_nettype none

module palette_color_fade_sequencer #(
    parameter int unsigned PALETTE_DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write port
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [pcfs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [pcfs_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // request stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // op[1:0], entry_index[5:2], entry_red[13:6], entry_green[21:14],
    // entry_blue[29:22], zero[31:30]
    input  wire logic [pcfs_pkg::TDATA_W-1:0]        i_s_axis_tdata,
    // result stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], finished[24], zero[31:25]
    output logic      [pcfs_pkg::TDATA_W-1:0]        o_m_axis_tdata
);

    localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
    localparam int unsigned WW    = (IDX_W > 4) ? IDX_W + 1 : 5;

    // ---------------- config registers ----------------
    logic [4:0] r_color_count;
    logic [7:0] r_step_width;
    logic [1:0] r_finish_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_count <= 5'd2;
            r_step_width  <= 8'd1;
            r_finish_mode <= pcfs_pkg::MODE_STOP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                pcfs_pkg::CFG_COLOR_COUNT: r_color_count <= i_cfg_wdata[4:0];
                pcfs_pkg::CFG_STEP_WIDTH:  r_step_width  <= i_cfg_wdata;
                pcfs_pkg::CFG_FINISH_MODE: r_finish_mode <= i_cfg_wdata[1:0];
                default: ;  // unmapped index is dropped
            endcase
        end
    end

    // ---------------- request decode ----------------
    logic           s_acc;
    logic [1:0]     req_op;
    logic [3:0]     req_index;
    pcfs_pkg::t_rgb req_rgb;

    assign s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign req_op        = i_s_axis_tdata[1:0];
    assign req_index     = i_s_axis_tdata[5:2];
    assign req_rgb.red   = i_s_axis_tdata[13:6];
    assign req_rgb.green = i_s_axis_tdata[21:14];
    assign req_rgb.blue  = i_s_axis_tdata[29:22];

    // ---------------- sequencer state ----------------
    pcfs_pkg::t_rgb       r_cur, n_cur;
    pcfs_pkg::t_rgb       r_tgt;          // target once the RAM read has landed
    logic                 r_tgt_pend;     // RAM output holds the fresh target
    pcfs_pkg::t_rgb       r_entry0;       // shadow of entry 0 for restart
    logic [IDX_W-1:0]     r_idx, n_idx;
    pcfs_pkg::t_seq_flags r_flags, n_flags;

    pcfs_pkg::t_rgb       ram_rdata;
    pcfs_pkg::t_rgb       eff_tgt;
    pcfs_pkg::t_rgb       stp_cur;
    logic [IDX_W-1:0]     stp_idx;
    pcfs_pkg::t_seq_flags stp_flags;
    logic                 stp_load;

    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     wr_addr;

    // target bypass: a load issued last cycle is still in the RAM output register
    assign eff_tgt = r_tgt_pend ? ram_rdata : r_tgt;

    pcfs_step #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_step (
        .i_cur         (r_cur),
        .i_tgt         (eff_tgt),
        .i_idx         (r_idx),
        .i_flags       (r_flags),
        .i_color_count (r_color_count),
        .i_step_width  (r_step_width),
        .i_finish_mode (r_finish_mode),
        .o_cur         (stp_cur),
        .o_idx         (stp_idx),
        .o_flags       (stp_flags),
        .o_load        (stp_load)
    );

    assign wr_addr = IDX_W'(req_index);

    always_comb begin
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_flags = r_flags;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        if (s_acc) begin
            unique case (pcfs_pkg::t_op'(req_op))
                pcfs_pkg::OP_TICK: begin
                    n_cur   = stp_cur;
                    n_idx   = stp_idx;
                    n_flags = stp_flags;
                    ram_re  = stp_load;
                end
                pcfs_pkg::OP_WRITE: begin
                    // index beyond the palette depth is ignored
                    ram_we = (WW'(req_index) < WW'(PALETTE_DEPTH));
                end
                pcfs_pkg::OP_RESTART: begin
                    n_cur   = r_entry0;
                    n_idx   = IDX_W'(1);
                    n_flags = '0;
                    ram_re  = 1'b1;
                end
                default: ;  // unused op: state holds
            endcase
        end
    end

    pcfs_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (req_rgb),
        .i_re    (ram_re),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur      <= '0;
            r_tgt      <= '0;
            r_tgt_pend <= 1'b0;
            r_idx      <= IDX_W'(1);
            r_flags    <= '0;
        end else begin
            r_cur      <= n_cur;
            r_tgt      <= eff_tgt;
            r_tgt_pend <= ram_re;
            r_idx      <= n_idx;
            r_flags    <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we && (wr_addr == '0)) r_entry0 <= req_rgb;
    end

    // ---------------- result output with skid stage ----------------
    logic [pcfs_pkg::TDATA_W-1:0] res_data;
    logic [pcfs_pkg::TDATA_W-1:0] r_out_data;
    logic [pcfs_pkg::TDATA_W-1:0] r_skid_data;
    logic                         r_out_valid;
    logic                         r_skid_valid;
    logic                         m_take;

    assign res_data = {7'd0, n_flags.halted, n_cur.blue, n_cur.green, n_cur.red};
    assign m_take   = r_out_valid && i_m_axis_tready;

    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= s_acc;
            end
        end else if (s_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_take) begin
            if (r_skid_valid) r_out_data <= r_skid_data;
            else if (s_acc)   r_out_data <= res_data;
        end else if (s_acc) begin
            r_skid_data <= res_data;
        end
    end

    // ---------------- assertions ----------------
    // skid entry only fills behind a held output
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid valid without output valid");

    // a restart clears both flags and points at entry 1
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && req_op == pcfs_pkg::OP_RESTART) |=>
            (r_idx == IDX_W'(1) && r_flags == '0 && r_tgt_pend))
        else $error("restart did not reload sequence state");

    // ping-pong state never coexists with the stop-once halt
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.halted |-> !r_flags.reversing)
        else $error("halted while reversing");

    // a halted sequencer ignores ticks
    a_halt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && req_op == pcfs_pkg::OP_TICK && r_flags.halted) |=>
            ($stable(r_cur) && $stable(r_idx) && !r_tgt_pend))
        else $error("tick changed state while halted");

endmodule

`default_nettype wire

FILE: rtl/core/pcfs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module pcfs_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/pcfs_step.sv
// Tick next-state: moves the color toward the target and advances the index.
// Depends on pcfs_pkg.
`default_nettype none

module pcfs_step #(
    parameter int unsigned PALETTE_DEPTH = 16
) (
    input  wire pcfs_pkg::t_rgb                      i_cur,
    input  wire pcfs_pkg::t_rgb                      i_tgt,
    input  wire logic [$clog2(PALETTE_DEPTH)-1:0]    i_idx,
    input  wire pcfs_pkg::t_seq_flags                i_flags,
    input  wire logic [4:0]                          i_color_count,
    input  wire logic [7:0]                          i_step_width,
    input  wire logic [1:0]                          i_finish_mode,
    output pcfs_pkg::t_rgb                           o_cur,
    output logic      [$clog2(PALETTE_DEPTH)-1:0]    o_idx,
    output pcfs_pkg::t_seq_flags                     o_flags,
    output logic                                     o_load
);

    localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);
    localparam int unsigned CW    = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;

    pcfs_pkg::t_rgb   moved;
    logic [CW-1:0]    cnt;
    logic [CW-1:0]    last;
    logic [CW-1:0]    idx_inc;
    logic [IDX_W-1:0] idx_a;
    logic             rev_a;
    logic             halt_a;

    always_comb begin
        moved.red   = pcfs_pkg::move_channel(i_cur.red,   i_tgt.red,   i_step_width);
        moved.green = pcfs_pkg::move_channel(i_cur.green, i_tgt.green, i_step_width);
        moved.blue  = pcfs_pkg::move_channel(i_cur.blue,  i_tgt.blue,  i_step_width);

        // clamp count to 2..depth
        cnt = CW'(i_color_count);
        if (cnt < CW'(2))             cnt = CW'(2);
        if (cnt > CW'(PALETTE_DEPTH)) cnt = CW'(PALETTE_DEPTH);
        last    = cnt - CW'(1);
        idx_inc = CW'(i_idx) + CW'(1);

        idx_a  = i_idx;
        rev_a  = i_flags.reversing;
        halt_a = 1'b0;
        if (!i_flags.reversing) begin
            if (idx_inc > last) begin
                if (i_finish_mode == pcfs_pkg::MODE_WRAP) begin
                    idx_a = '0;
                end else if (i_finish_mode == pcfs_pkg::MODE_PINGPONG) begin
                    rev_a = 1'b1;
                end else begin
                    halt_a = 1'b1;
                end
            end else begin
                idx_a = idx_inc[IDX_W-1:0];
            end
        end

        o_cur   = i_cur;
        o_idx   = i_idx;
        o_flags = i_flags;
        o_load  = 1'b0;
        if (!i_flags.halted) begin
            o_cur = moved;
            if (moved == i_tgt) begin
                o_load         = 1'b1;
                o_flags.halted = halt_a;
                if (rev_a) begin
                    if (idx_a == '0) begin
                        o_idx             = IDX_W'(1);
                        o_flags.reversing = 1'b0;
                    end else begin
                        o_idx             = idx_a - IDX_W'(1);
                        o_flags.reversing = 1'b1;
                    end
                end else begin
                    o_idx             = idx_a;
                    o_flags.reversing = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire
